/* rtl/rssm_pkg.sv */
// Shared constants, codes and command/status types of the reservoir sampler.
package rssm_pkg;

   localparam int MAX_SLOTS   = 1024;
   localparam int MAX_ENTRIES = 4096;
   localparam int SLOT_AW     = $clog2(MAX_SLOTS);
   localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = ENTRY_AW + 1;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_BUDGET   = 2'd1;
   localparam logic [1:0] CSR_LOG_RATE = 2'd2;

   localparam logic [31:0] CAPACITY_RESET = 32'd65536;
   localparam logic [31:0] BUDGET_RESET   = 32'd32768;
   localparam logic [31:0] LOG_RATE_RESET = 32'd1;

   typedef enum logic [1:0] {
      STAT_SAMPLED  = 2'd0,
      STAT_SKIPPED  = 2'd1,
      STAT_FILTERED = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_GO,
      ST_LOG_WAIT,
      ST_PICK,
      ST_IDX_GO,
      ST_IDX_WAIT,
      ST_DECIDE,
      ST_FIT,
      ST_CMP_RD,
      ST_CMP_WR,
      ST_REFIT,
      ST_SLOT_RD,
      ST_APPEND,
      ST_INVAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       div_go;
      logic       div_idx;
      logic       set_log;
      logic       take_idx;
      logic       bump_seen;
      logic       cmp_init;
      logic       cmp_step;
      logic       cmp_finish;
      logic       append;
      logic       inval;
      logic       finish;
      status_type status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic fixed;
      logic next_zero;
      logic sampled;
      logic fits;
      logic cmp_end;
   } dp_status_type;

endpackage

/* rtl/rssm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rssm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rssm_div.sv */
// Bit-serial 64-bit remainder unit, one quotient bit per cycle.
module rssm_div
   import rssm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] rem
);

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [64:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[63]};
      if (go) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // restore-free step: subtract when the partial remainder reaches the divisor
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = 64'(shifted - {1'b0, dvs_ff});
         end else begin
            rem_in = shifted[63:0];
         end
         quo_in = {quo_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (&cnt_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/rssm_ctrl.sv */
// Sequencing state machine of the reservoir sampler.
module rssm_ctrl
   import rssm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          pass,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   state_type  state_ff, state_in;
   status_type stat_ff, stat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stat_ff  <= STAT_SAMPLED;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      stat_in    = stat_ff;
      cmd        = '0;
      cmd.status = stat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (pass) begin
                  state_in = ST_LOG_GO;
               end else begin
                  stat_in  = STAT_FILTERED;
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOG_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_LOG_WAIT;
         end
         ST_LOG_WAIT: begin
            if (sts.div_done) begin
               cmd.set_log = 1'b1;
               state_in    = (sts.fixed && !sts.next_zero) ? ST_IDX_GO : ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.take_idx = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_IDX_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_idx = 1'b1;
            state_in    = ST_IDX_WAIT;
         end
         ST_IDX_WAIT: begin
            if (sts.div_done) begin
               cmd.take_idx = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.sampled) begin
               state_in = ST_FIT;
            end else begin
               cmd.bump_seen = 1'b1;
               stat_in       = STAT_SKIPPED;
               state_in      = ST_DONE;
            end
         end
         ST_FIT: begin
            if (sts.fits) begin
               state_in = ST_SLOT_RD;
            end else begin
               cmd.cmp_init = 1'b1;
               state_in     = ST_CMP_RD;
            end
         end
         ST_CMP_RD: begin
            if (sts.cmp_end) begin
               cmd.cmp_finish = 1'b1;
               state_in       = ST_REFIT;
            end else begin
               state_in = ST_CMP_WR;
            end
         end
         ST_CMP_WR: begin
            cmd.cmp_step = 1'b1;
            state_in     = ST_CMP_RD;
         end
         ST_REFIT: begin
            if (sts.fits) begin
               state_in = ST_SLOT_RD;
            end else begin
               stat_in  = STAT_OVERFLOW;
               state_in = ST_DONE;
            end
         end
         ST_SLOT_RD: begin
            state_in = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = ST_INVAL;
         end
         ST_INVAL: begin
            cmd.inval = 1'b1;
            stat_in   = STAT_SAMPLED;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/rssm_dp.sv */
// Datapath: counters, config registers, slot/entry stores, divider and result register.
module rssm_dp
   import rssm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type sts,
   input  logic [31:0]   req_stored_bytes,
   input  logic [30:0]   req_random_value,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [9:0]    rsp_slot_index,
   output logic [11:0]   rsp_buffer_position,
   output logic          rsp_compacted,
   output logic          rsp_log_sample,
   output logic [63:0]   rsp_records_seen,
   output logic [10:0]   rsp_reservoir_limit
);

   logic [31:0] cap_ff, bud_ff, rate_ff;
   logic [63:0] seen_ff;
   logic [10:0] lim_ff;
   logic        fixed_ff;
   logic [31:0] used_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [31:0]         size_ff;
   logic [30:0]         rnd_ff;
   logic [30:0]         idx_ff;
   logic                logf_ff, comp_ff, occ_ff;
   logic [ENTRY_AW-1:0] pos_ff, old_pos_ff;
   logic [COUNT_W-1:0]  e_ff, k_ff;
   logic [31:0]         tot_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [9:0]         rsp_slot_ff;
   logic [11:0]        rsp_pos_ff;
   logic               rsp_comp_ff, rsp_log_ff;
   logic [63:0]        rsp_seen_ff;
   logic [10:0]        rsp_lim_ff;

   logic [63:0] next_seen;
   logic [31:0] rate_eff, room, used_sum;
   logic [63:0] div_dividend, div_divisor, div_rem;
   logic        div_done;

   logic                size_we, valid_we, slot_we;
   logic [ENTRY_AW-1:0] size_waddr, valid_waddr;
   logic [SLOT_AW-1:0]  slot_waddr;
   logic [31:0]         size_wdata, size_rd;
   logic                valid_wdata, valid_rd;
   logic [ENTRY_AW-1:0] slot_wdata, slot_rd;

   assign next_seen = seen_ff + 64'd1;
   assign rate_eff  = (rate_ff == 32'd0) ? 32'd1 : rate_ff;
   assign room      = (used_ff >= cap_ff) ? 32'd0 : cap_ff - used_ff;
   assign used_sum  = used_ff + size_ff;

   always_comb begin
      sts.div_done  = div_done;
      sts.fixed     = fixed_ff;
      sts.next_zero = (next_seen == 64'd0);
      sts.sampled   = fixed_ff ? (idx_ff < 31'(lim_ff)) : (seen_ff < 64'(MAX_SLOTS));
      sts.fits      = (room >= size_ff) && (count_ff < COUNT_W'(MAX_ENTRIES));
      sts.cmp_end   = (e_ff >= count_ff);
   end

   assign div_dividend = cmd.div_idx ? {33'd0, rnd_ff} : seen_ff;
   assign div_divisor  = cmd.div_idx ? next_seen : {32'd0, rate_eff};

   rssm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .rem      (div_rem)
   );

   // store write steering: append, invalidate and compaction never share a cycle
   always_comb begin
      size_we     = cmd.append || (cmd.cmp_step && valid_rd);
      size_waddr  = cmd.append ? count_ff[ENTRY_AW-1:0] : k_ff[ENTRY_AW-1:0];
      size_wdata  = cmd.append ? size_ff : size_rd;
      valid_we    = cmd.append || (cmd.inval && occ_ff) || (cmd.cmp_step && valid_rd);
      valid_waddr = cmd.append ? count_ff[ENTRY_AW-1:0] :
                    cmd.inval  ? old_pos_ff : k_ff[ENTRY_AW-1:0];
      valid_wdata = !cmd.inval;
      slot_we     = cmd.append ||
                    (cmd.cmp_step && valid_rd && (k_ff < COUNT_W'(MAX_SLOTS)));
      slot_waddr  = cmd.append ? idx_ff[SLOT_AW-1:0] : k_ff[SLOT_AW-1:0];
      slot_wdata  = cmd.append ? count_ff[ENTRY_AW-1:0] : k_ff[ENTRY_AW-1:0];
   end

   rssm_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_size_ram (
      .clock   (clock),
      .wr_en   (size_we),
      .wr_addr (size_waddr),
      .wr_data (size_wdata),
      .rd_addr (e_ff[ENTRY_AW-1:0]),
      .rd_data (size_rd)
   );

   rssm_ram #(.WIDTH(1), .DEPTH(MAX_ENTRIES)) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_we),
      .wr_addr (valid_waddr),
      .wr_data (valid_wdata),
      .rd_addr (e_ff[ENTRY_AW-1:0]),
      .rd_data (valid_rd)
   );

   rssm_ram #(.WIDTH(ENTRY_AW), .DEPTH(MAX_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (idx_ff[SLOT_AW-1:0]),
      .rd_data (slot_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAPACITY_RESET;
         bud_ff       <= BUDGET_RESET;
         rate_ff      <= LOG_RATE_RESET;
         seen_ff      <= '0;
         lim_ff       <= '0;
         fixed_ff     <= 1'b0;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CAPACITY: cap_ff  <= csr_wdata;
               CSR_BUDGET:   bud_ff  <= csr_wdata;
               CSR_LOG_RATE: rate_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.bump_seen) begin
            seen_ff <= next_seen;
         end
         if (cmd.cmp_finish) begin
            count_ff <= k_ff;
            used_ff  <= tot_ff;
         end
         if (cmd.append) begin
            seen_ff  <= next_seen;
            count_ff <= count_ff + COUNT_W'(1);
            used_ff  <= used_sum;
            if (!fixed_ff && ((used_sum > bud_ff) || (next_seen >= 64'(MAX_SLOTS)))) begin
               fixed_ff <= 1'b1;
               lim_ff   <= next_seen[10:0];
            end
         end
         rsp_valid_ff <= cmd.finish;
      end

      if (cmd.capture) begin
         size_ff <= req_stored_bytes;
         rnd_ff  <= req_random_value;
         logf_ff <= 1'b0;
         comp_ff <= 1'b0;
      end
      if (cmd.set_log) begin
         logf_ff <= (div_rem == 64'd0);
      end
      if (cmd.take_idx) begin
         idx_ff <= !fixed_ff ? seen_ff[30:0] :
                   (next_seen == 64'd0) ? rnd_ff : div_rem[30:0];
      end
      if (cmd.cmp_init) begin
         e_ff    <= '0;
         k_ff    <= '0;
         tot_ff  <= '0;
         comp_ff <= 1'b1;
      end
      if (cmd.cmp_step) begin
         e_ff <= e_ff + COUNT_W'(1);
         if (valid_rd) begin
            k_ff   <= k_ff + COUNT_W'(1);
            tot_ff <= tot_ff + size_rd;
         end
      end
      if (cmd.append) begin
         pos_ff     <= count_ff[ENTRY_AW-1:0];
         old_pos_ff <= slot_rd;
         occ_ff     <= fixed_ff || ({1'b0, idx_ff} < seen_ff[31:0]);
      end
      if (cmd.finish) begin
         rsp_status_ff <= cmd.status;
         rsp_slot_ff   <= (cmd.status == STAT_SAMPLED) ? idx_ff[9:0] : 10'd0;
         rsp_pos_ff    <= (cmd.status == STAT_SAMPLED) ? pos_ff : 12'd0;
         rsp_comp_ff   <= comp_ff;
         rsp_log_ff    <= logf_ff;
         rsp_seen_ff   <= seen_ff;
         rsp_lim_ff    <= fixed_ff ? lim_ff : 11'd0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_buffer_position = rsp_pos_ff;
   assign rsp_compacted       = rsp_comp_ff;
   assign rsp_log_sample      = rsp_log_ff;
   assign rsp_records_seen    = rsp_seen_ff;
   assign rsp_reservoir_limit = rsp_lim_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table depth");

   a_cmp_order: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp_step |-> (k_ff <= e_ff))
      else $error("compaction write pointer overtook read pointer");

   a_limit_range: assert property (@(posedge clock) disable iff (reset)
      fixed_ff |-> (lim_ff != 11'd0) && (lim_ff <= 11'(MAX_SLOTS)))
      else $error("frozen limit out of range");

   a_freeze_on_append: assert property (@(posedge clock) disable iff (reset)
      $rose(fixed_ff) |-> $past(cmd.append))
      else $error("limit froze without an append");

endmodule

/* rtl/reservoir_sample_slot_manager.sv */
// Top level of the reservoir sampler with byte budget: controller plus datapath.
//
//  channel   direction  handshake              payload
//  req       in         start & !busy          req_filter_pass, req_stored_bytes,
//                                              req_random_value
//  rsp       out        rsp_valid (1 cycle)    rsp_status ... rsp_reservoir_limit
//  csr       in         csr_valid & csr_ready  csr_index, csr_wdata
//
// A filtered record goes straight to the done state. A passing record runs the 64-step
// remainder unit for the log flag. A closed reservoir runs the unit again for the
// replacement draw; an open one picks its slot without it. A compaction walks the
// table entries one by one; an overflow drops the 3 append steps. busy falls while
// the rsp beat shows, so the next req can land then.
// Reset is synchronous: counters, limit and config return to their reset values;
// the entry and slot stores need no clearing pass.
// The receiver cannot stall: each rsp beat is shown for exactly one cycle.
module reservoir_sample_slot_manager
   import rssm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_filter_pass,
   input  logic [31:0] req_stored_bytes,
   input  logic [30:0] req_random_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_slot_index,
   output logic [11:0] rsp_buffer_position,
   output logic        rsp_compacted,
   output logic        rsp_log_sample,
   output logic [63:0] rsp_records_seen,
   output logic [10:0] rsp_reservoir_limit,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // hold config beats off while a record is in flight
   assign csr_ready = !busy;

   rssm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .pass  (req_filter_pass),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   rssm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_stored_bytes    (req_stored_bytes),
      .req_random_value    (req_random_value),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_buffer_position (rsp_buffer_position),
      .rsp_compacted       (rsp_compacted),
      .rsp_log_sample      (rsp_log_sample),
      .rsp_records_seen    (rsp_records_seen),
      .rsp_reservoir_limit (rsp_reservoir_limit)
   );

endmodule
